@@ sv/nnsa_pkg.sv @@
// shared widths, register codes, reset values and stage control type
package nnsa_pkg;

  // fixed field widths
  localparam int COORD_W     = 12;
  localparam int DIM_REG_W   = 13;
  localparam int BPP_W       = 2;
  localparam int OFFSET_W    = 26;
  localparam int CFG_INDEX_W = 3;

  // default largest image dimension
  localparam int DEF_MAX_DIM = 4096;

  // register reset values
  localparam int RESET_SRC_WIDTH  = 640;
  localparam int RESET_SRC_HEIGHT = 480;
  localparam int RESET_DST_WIDTH  = 640;
  localparam int RESET_DST_HEIGHT = 480;

  // bytes per pixel code for gray, every other code means three bytes
  localparam logic [BPP_W-1:0] BPP_GRAY = 2'd1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_BPP        = 3'd4
  } cfg_reg_e;

  // control that travels with each beat through the pipeline
  typedef struct packed {
    logic valid;
    logic over_col;
    logic over_row;
  } stage_ctl_t;

endpackage

@@ sv/nnsa_dst_if.sv @@
// channel carrying destination pixel coordinates
interface nnsa_dst_if
  import nnsa_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dst_col;
  logic [COORD_W-1:0] dst_row;

  modport source (output valid, output dst_col, output dst_row, input ready);
  modport sink   (input valid, input dst_col, input dst_row, output ready);
endinterface

@@ sv/nnsa_src_if.sv @@
// channel carrying the selected source pixel and its byte offset
interface nnsa_src_if
  import nnsa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  src_col;
  logic [COORD_W-1:0]  src_row;
  logic [OFFSET_W-1:0] byte_offset;

  modport source (output valid, output src_col, output src_row, output byte_offset,
                  input ready);
  modport sink   (input valid, input src_col, input src_row, input byte_offset,
                  output ready);
endinterface

@@ sv/nnsa_front.sv @@
// first stage: scale coordinates by source size and flag out-of-range coordinates
module nnsa_front
  import nnsa_pkg::*;
#(
  parameter int DIM_W = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [COORD_W-1:0]         dst_col,
  input  logic [COORD_W-1:0]         dst_row,
  input  logic [DIM_W-1:0]           src_w,
  input  logic [DIM_W-1:0]           src_h,
  input  logic [DIM_W-1:0]           dst_w,
  input  logic [DIM_W-1:0]           dst_h,
  output stage_ctl_t                 ctl,
  output logic [COORD_W+DIM_W-1:0]   rem_col,
  output logic [COORD_W+DIM_W-1:0]   rem_row
);

  localparam int PW = COORD_W + DIM_W;
  localparam int XW = (DIM_W > COORD_W) ? DIM_W : COORD_W;

  logic valid;
  logic over_col;
  logic over_row;

  // beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // products and range flags
  always_ff @(posedge clk) begin
    if (en) begin
      rem_col  <= PW'(dst_col) * PW'(src_w);
      rem_row  <= PW'(dst_row) * PW'(src_h);
      over_col <= XW'(dst_col) >= XW'(dst_w);
      over_row <= XW'(dst_row) >= XW'(dst_h);
    end
  end

  assign ctl = '{valid: valid, over_col: over_col, over_row: over_row};

endmodule

@@ sv/nnsa_div_step.sv @@
// one restoring division step for both lanes, one quotient bit each
module nnsa_div_step
  import nnsa_pkg::*;
#(
  parameter int DIM_W = 13,
  parameter int QUO_W = 12,
  parameter int SHIFT = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  stage_ctl_t               ctl_in,
  input  logic [COORD_W+DIM_W-1:0] rem_col_in,
  input  logic [COORD_W+DIM_W-1:0] rem_row_in,
  input  logic [QUO_W-1:0]         q_col_in,
  input  logic [QUO_W-1:0]         q_row_in,
  input  logic [DIM_W-1:0]         dst_w,
  input  logic [DIM_W-1:0]         dst_h,
  output stage_ctl_t               ctl,
  output logic [COORD_W+DIM_W-1:0] rem_col,
  output logic [COORD_W+DIM_W-1:0] rem_row,
  output logic [QUO_W-1:0]         q_col,
  output logic [QUO_W-1:0]         q_row
);

  localparam int PW = COORD_W + DIM_W;
  localparam int CW = (PW > DIM_W + QUO_W) ? PW : DIM_W + QUO_W;

  logic          valid;
  logic          over_col;
  logic          over_row;
  logic [CW-1:0] div_col;
  logic [CW-1:0] div_row;
  logic          ge_col;
  logic          ge_row;
  logic [PW-1:0] rem_col_next;
  logic [PW-1:0] rem_row_next;

  // compare and subtract the shifted divisor
  always_comb begin
    div_col      = CW'(dst_w) << SHIFT;
    div_row      = CW'(dst_h) << SHIFT;
    ge_col       = CW'(rem_col_in) >= div_col;
    ge_row       = CW'(rem_row_in) >= div_row;
    rem_col_next = ge_col ? PW'(CW'(rem_col_in) - div_col) : rem_col_in;
    rem_row_next = ge_row ? PW'(CW'(rem_row_in) - div_row) : rem_row_in;
  end

  // beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  // partial remainders and quotients
  always_ff @(posedge clk) begin
    if (en) begin
      over_col <= ctl_in.over_col;
      over_row <= ctl_in.over_row;
      rem_col  <= rem_col_next;
      rem_row  <= rem_row_next;
      q_col    <= {q_col_in[QUO_W-2:0], ge_col};
      q_row    <= {q_row_in[QUO_W-2:0], ge_row};
    end
  end

  assign ctl = '{valid: valid, over_col: over_col, over_row: over_row};

endmodule

@@ sv/nnsa_back.sv @@
// last three stages: clamp, row times width, add column, scale by bytes per pixel
module nnsa_back
  import nnsa_pkg::*;
#(
  parameter int DIM_W = 13,
  parameter int QUO_W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          en,
  input  stage_ctl_t          ctl_in,
  input  logic [QUO_W-1:0]    q_col,
  input  logic [QUO_W-1:0]    q_row,
  input  logic [DIM_W-1:0]    src_w,
  input  logic [DIM_W-1:0]    src_h,
  input  logic                one_byte,
  output logic [2:0]          valid,
  output logic [COORD_W-1:0]  src_col,
  output logic [COORD_W-1:0]  src_row,
  output logic [OFFSET_W-1:0] byte_offset
);

  localparam int MW = QUO_W + DIM_W;

  logic [QUO_W-1:0]    col_clamped;
  logic [QUO_W-1:0]    row_clamped;
  logic [MW-1:0]       line_prod;
  logic [QUO_W-1:0]    col1;
  logic [QUO_W-1:0]    row1;
  logic [OFFSET_W-1:0] prod1;
  logic [QUO_W-1:0]    col2;
  logic [QUO_W-1:0]    row2;
  logic [OFFSET_W-1:0] sum2;

  // clamp to the last source column and row
  always_comb begin
    col_clamped = ctl_in.over_col ? QUO_W'(src_w - DIM_W'(1)) : q_col;
    row_clamped = ctl_in.over_row ? QUO_W'(src_h - DIM_W'(1)) : q_row;
    line_prod   = MW'(row_clamped) * MW'(src_w);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= ctl_in.valid;
      end
      if (en[1]) begin
        valid[1] <= valid[0];
      end
      if (en[2]) begin
        valid[2] <= valid[1];
      end
    end
  end

  // row start offset in pixels
  always_ff @(posedge clk) begin
    if (en[0]) begin
      col1  <= col_clamped;
      row1  <= row_clamped;
      prod1 <= OFFSET_W'(line_prod);
    end
  end

  // pixel index
  always_ff @(posedge clk) begin
    if (en[1]) begin
      col2 <= col1;
      row2 <= row1;
      sum2 <= prod1 + OFFSET_W'(col1);
    end
  end

  // output register, byte offset
  always_ff @(posedge clk) begin
    if (en[2]) begin
      src_col     <= COORD_W'(col2);
      src_row     <= COORD_W'(row2);
      byte_offset <= one_byte ? sum2 : sum2 + {sum2[OFFSET_W-2:0], 1'b0};
    end
  end

endmodule

@@ sv/nearest_neighbor_scale_address.sv @@
// Nearest-neighbor scaling address generator, top level.
//
// dst_pix takes one destination coordinate (dst_col, dst_row) per beat;
// src_pix returns the chosen source column and row, clamped to the last
// source column and row, and the byte offset of that pixel in a packed
// buffer of one (gray) or three (BGR) bytes per pixel.
// Sizes and pixel format are set through cfg_we / cfg_index / cfg_data;
// write them only while no beat is in flight. Sizes are held saturated
// to 1..MAX_DIM.
// Throughput is one beat per cycle while src_pix.ready is high. Each beat
// passes through one multiply stage, one restoring-division stage per
// quotient bit, then clamp/multiply, add and scale stages.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up and input beats are still taken
// while a result waits at the output. When src_pix.ready stays low the
// pipeline fills and dst_pix.ready drops; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and sets 640 x 480 to
// 640 x 480 at three bytes per pixel. No clearing pass is needed.
module nearest_neighbor_scale_address
  import nnsa_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DIM_REG_W-1:0]   cfg_data,
  nnsa_dst_if.sink               dst_pix,
  nnsa_src_if.source             src_pix
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int QUO_W  = $clog2(MAX_DIM);
  localparam int PW     = COORD_W + DIM_W;
  localparam int XW     = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam int STAGES = QUO_W + 4;

  localparam logic [DIM_W-1:0] RST_SRC_W =
    DIM_W'((RESET_SRC_WIDTH > MAX_DIM) ? MAX_DIM : RESET_SRC_WIDTH);
  localparam logic [DIM_W-1:0] RST_SRC_H =
    DIM_W'((RESET_SRC_HEIGHT > MAX_DIM) ? MAX_DIM : RESET_SRC_HEIGHT);
  localparam logic [DIM_W-1:0] RST_DST_W =
    DIM_W'((RESET_DST_WIDTH > MAX_DIM) ? MAX_DIM : RESET_DST_WIDTH);
  localparam logic [DIM_W-1:0] RST_DST_H =
    DIM_W'((RESET_DST_HEIGHT > MAX_DIM) ? MAX_DIM : RESET_DST_HEIGHT);

  logic [DIM_W-1:0] src_w;
  logic [DIM_W-1:0] src_h;
  logic [DIM_W-1:0] dst_w;
  logic [DIM_W-1:0] dst_h;
  logic             one_byte;
  logic [DIM_W-1:0] cfg_dim;

  logic [STAGES:0]   en;
  logic [STAGES-1:0] v;

  stage_ctl_t       div_ctl [QUO_W+1];
  logic [PW-1:0]    rem_col [QUO_W+1];
  logic [PW-1:0]    rem_row [QUO_W+1];
  logic [QUO_W-1:0] q_col   [QUO_W+1];
  logic [QUO_W-1:0] q_row   [QUO_W+1];
  logic [2:0]       back_v;

  // saturate a written dimension to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_REG_W-1:0] val);
    logic [XW-1:0] wide;
    wide = XW'(val);
    if (wide == '0) begin
      return DIM_W'(1);
    end else if (wide > XW'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(wide);
  endfunction

  assign cfg_dim = sat_dim(cfg_data);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w    <= RST_SRC_W;
      src_h    <= RST_SRC_H;
      dst_w    <= RST_DST_W;
      dst_h    <= RST_DST_H;
      one_byte <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_SRC_WIDTH:  src_w    <= cfg_dim;
        REG_SRC_HEIGHT: src_h    <= cfg_dim;
        REG_DST_WIDTH:  dst_w    <= cfg_dim;
        REG_DST_HEIGHT: dst_h    <= cfg_dim;
        REG_BPP:        one_byte <= cfg_data[BPP_W-1:0] == BPP_GRAY;
        default: ;
      endcase
    end
  end

  // stage load enables: a stage loads when empty or when its successor moves
  assign en[STAGES] = src_pix.ready;
  for (genvar g = 0; g < STAGES; g++) begin : g_en
    assign en[g] = !v[g] || en[g+1];
  end

  assign dst_pix.ready = en[0];

  // scale by source size
  nnsa_front #(
    .DIM_W (DIM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en[0]),
    .in_valid (dst_pix.valid),
    .dst_col  (dst_pix.dst_col),
    .dst_row  (dst_pix.dst_row),
    .src_w    (src_w),
    .src_h    (src_h),
    .dst_w    (dst_w),
    .dst_h    (dst_h),
    .ctl      (div_ctl[0]),
    .rem_col  (rem_col[0]),
    .rem_row  (rem_row[0])
  );

  assign q_col[0] = '0;
  assign q_row[0] = '0;
  assign v[0]     = div_ctl[0].valid;

  // divide by destination size, most significant quotient bit first
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    nnsa_div_step #(
      .DIM_W (DIM_W),
      .QUO_W (QUO_W),
      .SHIFT (QUO_W - 1 - i)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .en         (en[i+1]),
      .ctl_in     (div_ctl[i]),
      .rem_col_in (rem_col[i]),
      .rem_row_in (rem_row[i]),
      .q_col_in   (q_col[i]),
      .q_row_in   (q_row[i]),
      .dst_w      (dst_w),
      .dst_h      (dst_h),
      .ctl        (div_ctl[i+1]),
      .rem_col    (rem_col[i+1]),
      .rem_row    (rem_row[i+1]),
      .q_col      (q_col[i+1]),
      .q_row      (q_row[i+1])
    );
    assign v[i+1] = div_ctl[i+1].valid;
  end

  // clamp and byte offset
  nnsa_back #(
    .DIM_W (DIM_W),
    .QUO_W (QUO_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en[STAGES-1:STAGES-3]),
    .ctl_in      (div_ctl[QUO_W]),
    .q_col       (q_col[QUO_W]),
    .q_row       (q_row[QUO_W]),
    .src_w       (src_w),
    .src_h       (src_h),
    .one_byte    (one_byte),
    .valid       (back_v),
    .src_col     (src_pix.src_col),
    .src_row     (src_pix.src_row),
    .byte_offset (src_pix.byte_offset)
  );

  assign v[STAGES-1:STAGES-3] = back_v;
  assign src_pix.valid        = back_v[2];

endmodule

@@ sv/nnsa_checker.sv @@
// port-level checks for the scaling address generator, bound to the top level
module nnsa_checker
  import nnsa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COORD_W-1:0]  src_col,
  input logic [COORD_W-1:0]  src_row,
  input logic [OFFSET_W-1:0] byte_offset
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input side only blocks when the pipeline is full and the output stalls
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input not ready without an output stall");

  // an empty output stage never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  // a stalled result beat holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(src_col) && $stable(src_row) && $stable(byte_offset)))
    else $error("stalled result beat changed");

endmodule

bind nearest_neighbor_scale_address nnsa_checker u_nnsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (dst_pix.ready),
  .out_valid   (src_pix.valid),
  .out_ready   (src_pix.ready),
  .src_col     (src_pix.src_col),
  .src_row     (src_pix.src_row),
  .byte_offset (src_pix.byte_offset)
);

@@ dv/tb_nearest_neighbor_scale_address.sv @@
// testbench for the nearest-neighbor scaling address generator
module tb_nearest_neighbor_scale_address;
  import nnsa_pkg::*;

  // bytes per pixel code for BGR, the reset setting
  localparam logic [BPP_W-1:0] BPP_BGR = 2'd3;
  // cycles from an input beat to its result, plus margin
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 9;
  localparam int COORDS_PER_PHASE = 50;

  typedef struct {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [OFFSET_W-1:0] offset;
  } src_pixel_t;

  // predicts the source pixel of each destination coordinate and checks results in order
  class src_pixel_checker;
    logic [DIM_REG_W-1:0] src_w;
    logic [DIM_REG_W-1:0] src_h;
    logic [DIM_REG_W-1:0] dst_w;
    logic [DIM_REG_W-1:0] dst_h;
    logic [BPP_W-1:0]     bpp_code;
    src_pixel_t           due_pixels[$];
    int                   errors;

    function new();
      src_w    = DIM_REG_W'(RESET_SRC_WIDTH);
      src_h    = DIM_REG_W'(RESET_SRC_HEIGHT);
      dst_w    = DIM_REG_W'(RESET_DST_WIDTH);
      dst_h    = DIM_REG_W'(RESET_DST_HEIGHT);
      bpp_code = BPP_BGR;
      errors   = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DIM_REG_W-1:0] data);
      case (idx)
        REG_SRC_WIDTH:  src_w = data;
        REG_SRC_HEIGHT: src_h = data;
        REG_DST_WIDTH:  dst_w = data;
        REG_DST_HEIGHT: dst_h = data;
        REG_BPP:        bpp_code = data[BPP_W-1:0];
        default: ;
      endcase
    endfunction

    // size as the block uses it, saturated to 1..max
    function longint unsigned eff_dim(logic [DIM_REG_W-1:0] r);
      if (r == 0) return 1;
      if (r > DEF_MAX_DIM) return DEF_MAX_DIM;
      return 64'(r);
    endfunction

    function src_pixel_t map_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      longint unsigned sw, sh, dw, dh, bpp, c, r, off;
      src_pixel_t      p;
      sw  = eff_dim(src_w);
      sh  = eff_dim(src_h);
      dw  = eff_dim(dst_w);
      dh  = eff_dim(dst_h);
      bpp = (bpp_code == BPP_GRAY) ? 1 : 3;
      c = (longint'(x) * sw) / dw;
      r = (longint'(y) * sh) / dh;
      // clamp to the last source column and row
      if (c >= sw) c = sw - 1;
      if (r >= sh) r = sh - 1;
      off = (r * sw + c) * bpp;
      p.col    = c[COORD_W-1:0];
      p.row    = r[COORD_W-1:0];
      p.offset = off[OFFSET_W-1:0];
      return p;
    endfunction

    function void take_coord(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      due_pixels.push_back(map_coord(x, y));
    endfunction

    function void match_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic [OFFSET_W-1:0] offset);
      src_pixel_t want;
      if (due_pixels.size() == 0) begin
        $display("%0t: unexpected source pixel col %0d row %0d offset %0d",
                 $time, col, row, offset);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      if (col !== want.col) begin
        $display("%0t: src_col expected %0d got %0d", $time, want.col, col);
        errors++;
      end
      if (row !== want.row) begin
        $display("%0t: src_row expected %0d got %0d", $time, want.row, row);
        errors++;
      end
      if (offset !== want.offset) begin
        $display("%0t: byte_offset expected %0d got %0d", $time, want.offset, offset);
        errors++;
      end
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [DIM_REG_W-1:0]   cfg_data;

  nnsa_dst_if dst_pix();
  nnsa_src_if src_pix();

  nearest_neighbor_scale_address dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dst_pix   (dst_pix),
    .src_pix   (src_pix)
  );

  src_pixel_checker book = new();
  bit src_idle;
  bit snk_idle;
  int stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mix of extremes, out-of-range codes and ordinary sizes
  function automatic logic [DIM_REG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return DIM_REG_W'($urandom_range(DEF_MAX_DIM + 1, (1 << DIM_REG_W) - 1));
      2: return DIM_REG_W'(DEF_MAX_DIM);
      3: return DIM_REG_W'(1);
      4, 5: return DIM_REG_W'($urandom_range(1, 64));
      default: return DIM_REG_W'($urandom_range(1, DEF_MAX_DIM));
    endcase
  endfunction

  // coordinate mostly inside the destination size, sometimes anywhere
  function automatic logic [COORD_W-1:0] pick_coord(logic [DIM_REG_W-1:0] dim_reg);
    longint unsigned d;
    int r;
    d = book.eff_dim(dim_reg);
    r = $urandom_range(0, 99);
    if (r < 10) return COORD_W'(d - 1);
    if (r < 82) return COORD_W'($urandom_range(0, 32'(d - 1)));
    return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
  endfunction

  // output side: ready with random stalls
  initial begin
    src_pix.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        src_pix.ready = 1'b0;
        stall_left--;
      end else begin
        src_pix.ready = 1'b1;
        if (snk_idle) stall_left = pick_gap();
      end
    end
  end

  // result check on each accepted output beat
  always @(posedge clk) begin
    if (!rst && src_pix.valid && src_pix.ready)
      book.match_pixel(src_pix.src_col, src_pix.src_row, src_pix.byte_offset);
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [DIM_REG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    book.set_reg(idx, data);
  endtask

  task automatic write_config(input logic [DIM_REG_W-1:0] sw, input logic [DIM_REG_W-1:0] sh,
                              input logic [DIM_REG_W-1:0] dw, input logic [DIM_REG_W-1:0] dh,
                              input logic [DIM_REG_W-1:0] bpp);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_BPP, bpp);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one destination coordinate beat, held until taken
  task automatic send_coord(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      dst_pix.valid = 1'b0;
    end
    @(negedge clk);
    dst_pix.valid   = 1'b1;
    dst_pix.dst_col = x;
    dst_pix.dst_row = y;
    do @(posedge clk); while (!dst_pix.ready);
    book.take_coord(x, y);
  endtask

  // wait until every expected pixel has come out
  task automatic drain();
    @(negedge clk);
    dst_pix.valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_SRC_WIDTH;
    cfg_data        = '0;
    dst_pix.valid   = 1'b0;
    dst_pix.dst_col = '0;
    dst_pix.dst_row = '0;
    src_idle        = 1'b1;
    snk_idle        = 1'b1;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // reset sizes: corners, beyond destination size, alternating bits
    send_coord(12'd0, 12'd0);
    send_coord(12'd639, 12'd479);
    send_coord(12'd640, 12'd480);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'hAAA, 12'h555);
    send_coord(12'h555, 12'hAAA);
    drain();

    // largest source onto a single pixel, gray
    write_config(13'd4096, 13'd4096, 13'd1, 13'd1, 13'(BPP_GRAY));
    send_coord(12'd0, 12'd0);
    send_coord(12'd1, 12'd0);
    send_coord(12'd0, 12'd1);
    send_coord(12'hFFF, 12'hFFF);
    drain();

    // zero source size taken as one, oversized destination saturated
    write_config(13'd0, 13'd0, 13'h1FFF, 13'h1FFF, 13'd2);
    send_coord(12'd0, 12'd0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'd2048, 12'd1);
    drain();

    // oversized source saturated, zero destination taken as one, bpp code zero
    write_config(13'h1FFF, 13'h1FFF, 13'd0, 13'd0, 13'h1FFC);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'd0, 12'hFFF);
    send_coord(12'hFFF, 12'd0);
    drain();

    // full size both sides, largest offset
    write_config(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'h1FFF);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'd1234, 12'd3210);
    drain();

    // random phases, cycling through the idle patterns of both sides
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      src_idle = p[0];
      snk_idle = p[1];
      write_config(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                   DIM_REG_W'($urandom_range(0, (1 << DIM_REG_W) - 1)));
      for (int i = 0; i < COORDS_PER_PHASE; i++)
        send_coord(pick_coord(book.dst_w), pick_coord(book.dst_h));
      drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/nnsa_pkg.sv
sv/nnsa_dst_if.sv
sv/nnsa_src_if.sv
sv/nnsa_front.sv
sv/nnsa_div_step.sv
sv/nnsa_back.sv
sv/nearest_neighbor_scale_address.sv
sv/nnsa_checker.sv
dv/tb_nearest_neighbor_scale_address.sv
